FILE: hdl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants and types of the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int RX_BUF_SIZE  = 32;
	localparam int PLATE_BYTES  = 16;
	localparam int MAX_READ_LEN = 15;

	localparam int BANK_AW = $clog2(RX_BUF_SIZE);
	localparam int ADDR_W  = BANK_AW + 1;
	localparam int WIDX_W  = BANK_AW;
	localparam int PLEN_W  = $clog2(PLATE_BYTES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RECV = 2'd1;
	localparam logic [1:0] ST_HELD = 2'd2;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] CFG_START_BYTE = 2'd0;
	localparam logic [1:0] CFG_END_BYTE   = 2'd1;
	localparam logic [1:0] CFG_COOLDOWN   = 2'd2;

	localparam logic [7:0]  START_BYTE_RST = 8'd255;
	localparam logic [7:0]  END_BYTE_RST   = 8'd254;
	localparam logic [15:0] COOLDOWN_RST   = 16'd10000;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic       available;
		logic       plate_valid;
		logic [3:0] plate_length;
		logic [1:0] parse_state;
		logic       frame_accepted;
		logic       frame_dropped;
		logic       rd_en;
	} res_t;

endpackage

FILE: hdl/delimited_frame_receiver_cooldown.sv
// ----------------------------------------------------------------------------
// delimited_frame_receiver_cooldown
// Start/end delimited serial frame receiver with an acceptance cooldown.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while in_stall is low; its result is
// registered in the output register, alongside the registered read of the payload buffer.
// Payload bytes and the held plate live in one two-bank memory: an accepted
// frame simply turns its bank into the plate bank, so no copy takes place.
// Results pass through an output register and a skid entry, and in_stall is
// high only while that skid entry is occupied. No clearing pass is needed
// after reset. Configuration writes are taken at once (cfg_ready is always
// high) and are meant to happen while the block is idle.
module delimited_frame_receiver_cooldown import dfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  char_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        available,
	output logic        plate_valid,
	output logic [3:0]  plate_length,
	output logic [7:0]  read_char,
	output logic [1:0]  parse_state,
	output logic        frame_accepted,
	output logic        frame_dropped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic       accept;
	logic       skid_full;
	mem_req_t   req;
	res_t       res;
	res_t       out_res;
	logic [7:0] rdata;

	assign in_stall  = skid_full;
	assign accept    = in_valid & ~skid_full;
	assign cfg_ready = 1'b1;

	dfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.char_index (char_index),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req),
		.res        (res)
	);

	dfr_buf u_buf (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	dfr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res       (res),
		.rdata     (rdata),
		.out_stall (out_stall),
		.skid_full (skid_full),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_char  (read_char)
	);

	assign available      = out_res.available;
	assign plate_valid    = out_res.plate_valid;
	assign plate_length   = out_res.plate_length;
	assign parse_state    = out_res.parse_state;
	assign frame_accepted = out_res.frame_accepted;
	assign frame_dropped  = out_res.frame_dropped;

endmodule

FILE: hdl/dfr_buf.sv
// ----------------------------------------------------------------------------
// dfr_buf
// Two-bank byte buffer: one bank fills with payload, the other holds the plate.
// ----------------------------------------------------------------------------
module dfr_buf import dfr_pkg::*; (
	input  logic       clk,
	input  mem_req_t   req,
	output logic [7:0] rdata
);

	logic [7:0] mem [2**ADDR_W];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/dfr_ctrl.sv
// ----------------------------------------------------------------------------
// dfr_ctrl
// Frame parser, plate bookkeeping, cooldown counter and configuration.
// ----------------------------------------------------------------------------
module dfr_ctrl import dfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  char_index,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output mem_req_t    req,
	output res_t        res
);

	logic [7:0]        start_q;
	logic [7:0]        end_q;
	logic [15:0]       cool_cfg_q;
	logic [1:0]        state_q, state_d;
	logic [WIDX_W-1:0] widx_q, widx_d;
	logic [PLEN_W-1:0] plen_q, plen_d;
	logic              pvalid_q, pvalid_d;
	logic [15:0]       cool_q, cool_d;
	logic              bank_q, bank_d;
	logic              acc, drop, rd_en, wr_en;
	logic [3:0]        shown_cur, shown_d;

	// Length as seen from outside: zero with no plate, capped at the read limit.
	always_comb begin
		shown_cur = '0;
		if (pvalid_q) begin
			shown_cur = (32'(plen_q) > MAX_READ_LEN) ? 4'(MAX_READ_LEN) : 4'(plen_q);
		end
		shown_d = '0;
		if (pvalid_d) begin
			shown_d = (32'(plen_d) > MAX_READ_LEN) ? 4'(MAX_READ_LEN) : 4'(plen_d);
		end
	end

	always_comb begin
		state_d  = state_q;
		widx_d   = widx_q;
		plen_d   = plen_q;
		pvalid_d = pvalid_q;
		cool_d   = cool_q;
		bank_d   = bank_q;
		acc      = 1'b0;
		drop     = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		case (opcode)
			OP_BYTE: begin
				case (state_q)
					ST_IDLE: begin
						if (data_byte == start_q) begin
							state_d = ST_RECV;
							widx_d  = '0;
						end
					end
					ST_RECV: begin
						if (data_byte == end_q) begin
							if (widx_q != '0 && 32'(widx_q) < PLATE_BYTES && cool_q == '0) begin
								// The filled bank becomes the plate bank; no copy needed.
								plen_d   = PLEN_W'(widx_q);
								pvalid_d = 1'b1;
								state_d  = ST_HELD;
								cool_d   = cool_cfg_q;
								bank_d   = ~bank_q;
								acc      = 1'b1;
							end else begin
								state_d = ST_IDLE;
								drop    = 1'b1;
							end
							widx_d = '0;
						end else if (32'(widx_q) < RX_BUF_SIZE - 1) begin
							wr_en  = 1'b1;
							widx_d = widx_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				if (cool_q != '0) begin
					cool_d = cool_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				state_d  = ST_IDLE;
				pvalid_d = 1'b0;
				plen_d   = '0;
			end
			default: begin
				rd_en = (char_index < shown_cur) && (32'(char_index) < PLATE_BYTES);
			end
		endcase
	end

	always_comb begin
		req.we    = accept & wr_en;
		req.re    = accept & rd_en;
		req.wdata = data_byte;
		if (opcode == OP_READ) begin
			req.addr = {~bank_q, BANK_AW'(char_index)};
		end else begin
			req.addr = {bank_q, widx_q};
		end
		res.available      = (state_d == ST_HELD);
		res.plate_valid    = pvalid_d;
		res.plate_length   = shown_d;
		res.parse_state    = state_d;
		res.frame_accepted = acc;
		res.frame_dropped  = drop;
		res.rd_en          = rd_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= START_BYTE_RST;
			end_q      <= END_BYTE_RST;
			cool_cfg_q <= COOLDOWN_RST;
			state_q    <= ST_IDLE;
			widx_q     <= '0;
			plen_q     <= '0;
			pvalid_q   <= 1'b0;
			cool_q     <= '0;
			bank_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_BYTE: start_q    <= cfg_data[7:0];
					CFG_END_BYTE:   end_q      <= cfg_data[7:0];
					CFG_COOLDOWN:   cool_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				state_q  <= state_d;
				widx_q   <= widx_d;
				plen_q   <= plen_d;
				pvalid_q <= pvalid_d;
				cool_q   <= cool_d;
				bank_q   <= bank_d;
			end
		end
	end

endmodule

FILE: hdl/dfr_out.sv
// ----------------------------------------------------------------------------
// dfr_out
// Result stage with a skid entry, so the input stall comes from a register.
// ----------------------------------------------------------------------------
module dfr_out import dfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  res_t       res,
	input  logic [7:0] rdata,
	input  logic       out_stall,
	output logic       skid_full,
	output logic       out_valid,
	output res_t       out_res,
	output logic [7:0] out_char
);

	logic       v_s1;
	res_t       res_s1;
	logic [7:0] char_s1;
	logic       sk_v_q;
	res_t       sk_res_q;
	logic [7:0] sk_char_q;
	logic       taken;

	// The memory read data lines up with the result registered in the same edge.
	assign char_s1   = res_s1.rd_en ? rdata : 8'd0;
	assign out_valid = sk_v_q | v_s1;
	assign out_res   = sk_v_q ? sk_res_q : res_s1;
	assign out_char  = sk_v_q ? sk_char_q : char_s1;
	assign taken     = out_valid & ~out_stall;
	assign skid_full = sk_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (taken) begin
				sk_v_q <= 1'b0;
			end
		end else if (accept) begin
			v_s1 <= 1'b1;
			if (v_s1 && !taken) begin
				sk_v_q <= 1'b1;
			end
		end else if (taken) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			if (v_s1 && !taken) begin
				sk_res_q  <= res_s1;
				sk_char_q <= char_s1;
			end
		end
	end

endmodule

FILE: tb/delimited_frame_receiver_cooldown_tb.sv
// ----------------------------------------------------------------------------
// delimited_frame_receiver_cooldown_tb
// Drives serial bytes, millisecond ticks, clears and plate reads into the
// frame receiver and checks every status result against a cycle-free copy of
// the parser, plate store and cooldown counter kept in this bench.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_cooldown_tb;
	import dfr_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		logic       available;
		logic       plate_valid;
		logic [3:0] plate_length;
		logic [7:0] read_char;
		logic [1:0] parse_state;
		logic       frame_accepted;
		logic       frame_dropped;
	} receiver_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic [3:0]  char_index = 4'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        available;
	logic        plate_valid;
	logic [3:0]  plate_length;
	logic [7:0]  read_char;
	logic [1:0]  parse_state;
	logic        frame_accepted;
	logic        frame_dropped;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_START_BYTE;
	logic [15:0] cfg_data = 16'h0000;

	// Bench copy of the configuration and of the receiver state.
	logic [7:0]  cfg_start_byte = START_BYTE_RST;
	logic [7:0]  cfg_end_byte = END_BYTE_RST;
	logic [15:0] cfg_cooldown = COOLDOWN_RST;
	logic [1:0]  rcv_state = ST_IDLE;
	logic [4:0]  rcv_fill = '0;
	logic [7:0]  rcv_buf [RX_BUF_SIZE];
	logic [7:0]  plate_chars [PLATE_BYTES];
	logic [3:0]  plate_count = '0;
	logic        plate_held = 1'b0;
	logic [15:0] cool_left = '0;

	receiver_status_t status_due [$];
	int unsigned fault_count = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	logic [9:0]  stall_tick = '0;

	delimited_frame_receiver_cooldown dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.data_byte(data_byte),
		.char_index(char_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.available(available),
		.plate_valid(plate_valid),
		.plate_length(plate_length),
		.read_char(read_char),
		.parse_state(parse_state),
		.frame_accepted(frame_accepted),
		.frame_dropped(frame_dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("delimited_frame_receiver_cooldown_tb failed");
		$finish;
	end

	// The bench cycles out_stall through four patterns: none, light, heavy and
	// a fixed periodic one.
	always @(negedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		case (stall_tick[9:8])
		2'd0: out_stall <= 1'b0;
		2'd1: out_stall <= ($urandom_range(0, 3) == 0);
		2'd2: out_stall <= ($urandom_range(0, 3) != 0);
		default: out_stall <= stall_tick[3] & stall_tick[1];
		endcase
	end

	// Advances the receiver copy by one request and queues the status it must
	// produce.
	task automatic advance_receiver(input logic [1:0] op, input logic [7:0] b,
			input logic [3:0] idx);
		receiver_status_t st;
		int i;
		st = '0;
		case (op)
		OP_BYTE: begin
			if (rcv_state == ST_IDLE) begin
				if (b == cfg_start_byte) begin
					rcv_state = ST_RECV;
					rcv_fill = '0;
				end
			end else if (rcv_state == ST_RECV) begin
				if (b == cfg_end_byte) begin
					if (rcv_fill != 0 && rcv_fill < PLATE_BYTES && cool_left == 0) begin
						for (i = 0; i < PLATE_BYTES; i++)
							plate_chars[i] = (i < rcv_fill) ? rcv_buf[i] : 8'h00;
						plate_count = rcv_fill[3:0];
						plate_held = 1'b1;
						rcv_state = ST_HELD;
						cool_left = cfg_cooldown;
						st.frame_accepted = 1'b1;
					end else begin
						rcv_state = ST_IDLE;
						st.frame_dropped = 1'b1;
					end
					rcv_fill = '0;
				end else if (rcv_fill < RX_BUF_SIZE - 1) begin
					rcv_buf[rcv_fill] = b;
					rcv_fill = rcv_fill + 1'b1;
				end
			end
		end
		OP_TICK: begin
			if (cool_left != 0)
				cool_left = cool_left - 1'b1;
		end
		OP_CLEAR: begin
			rcv_state = ST_IDLE;
			plate_held = 1'b0;
			plate_count = '0;
		end
		OP_READ: begin
			if (plate_held && idx < plate_count)
				st.read_char = plate_chars[idx];
		end
		default: ;
		endcase
		st.available = (rcv_state == ST_HELD);
		st.plate_valid = plate_held;
		st.plate_length = plate_held ? plate_count : 4'd0;
		st.parse_state = rcv_state;
		status_due.push_back(st);
	endtask

	always @(posedge clk) begin : check_status
		receiver_status_t got;
		receiver_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{available, plate_valid, plate_length, read_char, parse_state,
				frame_accepted, frame_dropped};
			if (status_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result with no request pending at cycle %0d", cycle_count);
			end else begin
				want = status_due.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("status mismatch at cycle %0d", cycle_count);
						$display("  expected avail %0d valid %0d len %0d char %02h state %0d acc %0d drop %0d",
							want.available, want.plate_valid, want.plate_length, want.read_char,
							want.parse_state, want.frame_accepted, want.frame_dropped);
						$display("  actual   avail %0d valid %0d len %0d char %02h state %0d acc %0d drop %0d",
							got.available, got.plate_valid, got.plate_length, got.read_char,
							got.parse_state, got.frame_accepted, got.frame_dropped);
					end
				end
			end
		end
	end

	// Sends one request, then may idle the sender for a random gap when a burst runs out.
	task automatic send_request(input logic [1:0] op, input logic [7:0] b,
			input logic [3:0] idx);
		int unsigned gap;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		char_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_receiver(op, b, idx);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(OP_BYTE, b, 4'($urandom_range(0, 15)));
	endtask

	task automatic send_tick();
		send_request(OP_TICK, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
	endtask

	task automatic send_clear();
		send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
	endtask

	task automatic send_read(input logic [3:0] idx);
		send_request(OP_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	// Holds the sender off until every queued status has come back.
	task automatic await_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		CFG_START_BYTE: cfg_start_byte = value[7:0];
		CFG_END_BYTE: cfg_end_byte = value[7:0];
		CFG_COOLDOWN: cfg_cooldown = value;
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] sb, input logic [7:0] eb,
			input logic [15:0] cd);
		await_results();
		write_register(CFG_START_BYTE, {8'h00, sb});
		write_register(CFG_END_BYTE, {8'h00, eb});
		write_register(CFG_COOLDOWN, cd);
	endtask

	// Payload bytes never equal the end byte, but zero and the start byte are
	// favored since both must be kept as plain characters.
	function automatic logic [7:0] payload_byte();
		logic [7:0] b;
		case ($urandom_range(0, 7))
		0: b = 8'h00;
		1: b = cfg_start_byte;
		default: b = 8'($urandom_range(0, 255));
		endcase
		while (b == cfg_end_byte)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic send_frame(input int unsigned len);
		send_byte(cfg_start_byte);
		repeat (len)
			send_byte(payload_byte());
		send_byte(cfg_end_byte);
	endtask

	// Mostly complete frames followed by reads, ticks and usually a clear; the rest is
	// aborted frames, stray ticks, reads, clears and line noise.
	task automatic run_traffic(input int unsigned quota);
		int unsigned target;
		int unsigned pick;
		int unsigned len;
		int unsigned tick_span;
		target = items_sent + quota;
		tick_span = (cfg_cooldown > 14) ? 16 : cfg_cooldown + 2;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				case ($urandom_range(0, 9))
				0: len = 0;
				1: len = $urandom_range(16, 20);
				2: len = $urandom_range(28, 40);
				default: len = $urandom_range(1, 15);
				endcase
				send_frame(len);
				repeat ($urandom_range(0, 4))
					send_read(4'($urandom_range(0, 15)));
				repeat ($urandom_range(0, tick_span))
					send_tick();
				if ($urandom_range(0, 3) != 0)
					send_clear();
			end else if (pick < 65) begin
				send_byte(cfg_start_byte);
				repeat ($urandom_range(0, 6))
					send_byte(payload_byte());
				if ($urandom_range(0, 1) == 0)
					send_clear();
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 10))
					send_tick();
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4))
					send_read(4'($urandom_range(0, 15)));
			end else if (pick < 92) begin
				send_clear();
			end else begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Reset delimiters and the long reset cooldown: the first frame passes,
	// the next one lands inside the cooldown.
	task automatic test_reset_registers();
		send_byte(START_BYTE_RST);
		send_byte(8'h00);
		send_byte(END_BYTE_RST);
		send_read(4'd0);
		send_read(4'd1);
		send_byte(START_BYTE_RST);
		send_clear();
		send_byte(START_BYTE_RST);
		send_byte(8'h41);
		send_byte(END_BYTE_RST);
		await_results();
	endtask

	// Extreme delimiters with no cooldown: an empty frame, a start byte kept
	// as payload, reads at the ends of the index range and back-to-back frames.
	task automatic test_zero_cooldown_frames();
		configure(8'h00, 8'hFF, 16'h0000);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h41);
		send_byte(8'hFF);
		send_read(4'd15);
		send_read(4'd1);
		send_tick();
		send_clear();
		send_byte(8'h00);
		send_byte(8'h5A);
		send_byte(8'hFF);
		send_read(4'd0);
	endtask

	task automatic test_random_delimiters();
		logic [7:0] sb;
		logic [7:0] eb;
		sb = 8'($urandom_range(0, 255));
		eb = 8'($urandom_range(0, 255));
		while (eb == sb)
			eb = 8'($urandom_range(0, 255));
		configure(sb, eb, 16'($urandom_range(1, 12)));
		run_traffic(425);
	endtask

	task automatic test_zero_cooldown_traffic();
		logic [7:0] sb;
		logic [7:0] eb;
		sb = 8'($urandom_range(0, 255));
		eb = ~sb;
		configure(sb, eb, 16'h0000);
		run_traffic(425);
	endtask

	// One byte value both opens and closes frames.
	task automatic test_shared_delimiter();
		logic [7:0] sb;
		sb = 8'($urandom_range(0, 255));
		configure(sb, sb, 16'($urandom_range(0, 6)));
		run_traffic(425);
	endtask

	// Once a frame is taken the cooldown never runs out in this phase.
	task automatic test_max_cooldown();
		configure(8'hFF, 8'h00, 16'hFFFF);
		run_traffic(425);
	endtask

	initial begin
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		test_reset_registers();
		test_zero_cooldown_frames();
		test_random_delimiters();
		test_zero_cooldown_traffic();
		test_shared_delimiter();
		test_max_cooldown();
		await_results();
		if (fault_count == 0 && status_due.size() == 0) begin
			$display("delimited_frame_receiver_cooldown_tb passed");
		end else begin
			$display("delimited_frame_receiver_cooldown_tb failed");
		end
		$finish;
	end

endmodule
